// ===== sv/bpm_pkg.sv =====
// shared types and constants for the battery protection monitor
package bpm_pkg;

   localparam int SAMPLE_W = 12;
   localparam int NEEDED_W = 4;
   localparam int CSR_IDX_W = 3;

   localparam int unsigned LOW_MARGIN_MV = 50;
   localparam logic [NEEDED_W-1:0] HIGH_COUNT_MAX = 4'd15;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CRITICAL_MV = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_MV      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RECOVER_MV  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_MV     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_NEEDED = 3'd4;

   // register reset values
   localparam logic [SAMPLE_W-1:0] CRITICAL_MV_RST = 12'd3100;
   localparam logic [SAMPLE_W-1:0] LOW_MV_RST      = 12'd3300;
   localparam logic [SAMPLE_W-1:0] RECOVER_MV_RST  = 12'd3400;
   localparam logic [SAMPLE_W-1:0] HIGH_MV_RST     = 12'd3500;
   localparam logic [NEEDED_W-1:0] HIGH_NEEDED_RST = 4'd4;

   typedef enum logic [1:0] {
      LVL_OK       = 2'd0,
      LVL_LOW      = 2'd1,
      LVL_CRITICAL = 2'd2,
      LVL_SHUTDOWN = 2'd3
   } level_type;

   typedef struct packed {
      logic capture;
      logic store;
      logic sum;
      logic mult;
      logic decide;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic shutdown;
      logic sum_done;
      logic out_free;
   } status_type;

endpackage

// ===== sv/bpm_ctrl.sv =====
// sequencing state machine for the battery protection monitor
module bpm_ctrl
   import bpm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_SUM,
      ST_MULT,
      ST_DECIDE,
      ST_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            // nothing moves once shut down
            if (status.shutdown) begin
               state_in = ST_FINISH;
            end else begin
               cmd.store = 1'b1;
               state_in  = ST_SUM;
            end
         end
         ST_SUM: begin
            cmd.sum = 1'b1;
            if (status.sum_done) begin
               state_in = ST_MULT;
            end
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

// ===== sv/bpm_datapath.sv =====
// history ring, counters, level logic and result register
module bpm_datapath
   import bpm_pkg::*;
#(
   parameter int HISTORY_DEPTH = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic [SAMPLE_W-1:0]   req_sample_mv,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [SAMPLE_W-1:0]   csr_wdata,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_monitor_state,
   output logic                  rsp_display_inhibit,
   output logic                  rsp_armed
);

   localparam int IDX_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
   localparam int SUM_W  = SAMPLE_W + CNT_W;
   localparam int LIM_W  = SAMPLE_W + 1;
   localparam int PROD_W = LIM_W + CNT_W;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(HISTORY_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(HISTORY_DEPTH);
   localparam logic [LIM_W-1:0] LIM_ADD  = LIM_W'(LOW_MARGIN_MV + 1);

   logic [SAMPLE_W-1:0] critical_ff;
   logic [SAMPLE_W-1:0] low_ff;
   logic [SAMPLE_W-1:0] recover_ff;
   logic [SAMPLE_W-1:0] high_ff;
   logic [NEEDED_W-1:0] needed_ff;

   logic [SAMPLE_W-1:0] hist_mem [HISTORY_DEPTH];
   logic [SAMPLE_W-1:0] sample_ff;
   logic [IDX_W-1:0]    wr_idx_ff;
   logic [CNT_W-1:0]    fill_ff;
   logic [NEEDED_W-1:0] high_cnt_ff;
   logic                armed_ff;
   level_type           level_ff;

   logic [CNT_W-1:0]    rd_idx_ff;
   logic [SAMPLE_W-1:0] rd_data_ff;
   logic                rd_vld_ff;
   logic                rd_en;
   logic [SUM_W-1:0]    sum_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic [LIM_W-1:0]    limit;

   logic [NEEDED_W-1:0] high_cnt_in;
   logic                armed_in;
   level_type           level_in;
   logic                avg_ok;

   logic                rsp_valid_ff;
   level_type           rsp_level_ff;
   logic                rsp_armed_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         critical_ff <= CRITICAL_MV_RST;
         low_ff      <= LOW_MV_RST;
         recover_ff  <= RECOVER_MV_RST;
         high_ff     <= HIGH_MV_RST;
         needed_ff   <= HIGH_NEEDED_RST;
      end else if (csr_write) begin
         case (csr_index)
            CSR_CRITICAL_MV: critical_ff <= csr_wdata;
            CSR_LOW_MV:      low_ff      <= csr_wdata;
            CSR_RECOVER_MV:  recover_ff  <= csr_wdata;
            CSR_HIGH_MV:     high_ff     <= csr_wdata;
            CSR_HIGH_NEEDED: needed_ff   <= csr_wdata[NEEDED_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sample_ff <= req_sample_mv;
      end
   end

   // history memory, one write and one registered read port
   assign rd_en = cmd.sum && (rd_idx_ff < fill_ff);

   always_ff @(posedge clock) begin
      if (cmd.store) begin
         hist_mem[wr_idx_ff] <= sample_ff;
      end
      if (rd_en) begin
         rd_data_ff <= hist_mem[rd_idx_ff[IDX_W-1:0]];
      end
   end

   // high sample counter saturates, armed compares the updated count
   always_comb begin
      high_cnt_in = high_cnt_ff;
      armed_in    = armed_ff;
      if (sample_ff >= high_ff) begin
         if (high_cnt_ff < HIGH_COUNT_MAX) begin
            high_cnt_in = high_cnt_ff + 1'b1;
         end
         if (high_cnt_in >= needed_ff) begin
            armed_in = 1'b1;
         end
      end
   end

   // average <= low + 50 is the same as sum < (low + 51) * fill
   assign limit  = {1'b0, low_ff} + LIM_ADD;
   assign avg_ok = PROD_W'(sum_ff) < prod_ff;

   always_comb begin
      level_in = level_ff;
      if (armed_ff) begin
         case (level_ff)
            LVL_OK: begin
               if (sample_ff <= critical_ff) begin
                  level_in = LVL_CRITICAL;
               end else if (sample_ff <= low_ff && avg_ok) begin
                  level_in = LVL_LOW;
               end
            end
            LVL_LOW: begin
               if (sample_ff <= critical_ff) begin
                  level_in = LVL_CRITICAL;
               end else if (sample_ff >= recover_ff) begin
                  level_in = LVL_OK;
               end
            end
            LVL_CRITICAL: level_in = LVL_SHUTDOWN;
            default:      level_in = level_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff   <= '0;
         fill_ff     <= '0;
         high_cnt_ff <= '0;
         armed_ff    <= 1'b0;
         level_ff    <= LVL_OK;
         rd_idx_ff   <= '0;
         rd_vld_ff   <= 1'b0;
      end else begin
         if (cmd.store) begin
            wr_idx_ff   <= (wr_idx_ff == IDX_LAST) ? '0 : wr_idx_ff + 1'b1;
            if (fill_ff < CNT_FULL) begin
               fill_ff <= fill_ff + 1'b1;
            end
            high_cnt_ff <= high_cnt_in;
            armed_ff    <= armed_in;
            rd_idx_ff   <= '0;
            rd_vld_ff   <= 1'b0;
         end else if (cmd.sum) begin
            if (rd_en) begin
               rd_idx_ff <= rd_idx_ff + 1'b1;
            end
            rd_vld_ff <= rd_en;
         end
         if (cmd.decide) begin
            level_ff <= level_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.store) begin
         sum_ff <= '0;
      end else if (cmd.sum && rd_vld_ff) begin
         sum_ff <= sum_ff + SUM_W'(rd_data_ff);
      end
      if (cmd.mult) begin
         prod_ff <= PROD_W'(limit) * PROD_W'(fill_ff);
      end
   end

   // result register, a new transaction loads as the old one leaves
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_level_ff <= level_ff;
         rsp_armed_ff <= armed_ff;
      end
   end

   assign status.shutdown = (level_ff == LVL_SHUTDOWN);
   assign status.sum_done = (rd_idx_ff == fill_ff) && !rd_vld_ff;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_monitor_state   = rsp_level_ff;
   assign rsp_display_inhibit = (rsp_level_ff != LVL_OK);
   assign rsp_armed           = rsp_armed_ff;

endmodule

// ===== sv/battery_protection_monitor.sv =====
// battery protection monitor top level
//
//   channel | ports                                   | direction
//   req     | req_valid, req_stall, req_sample_mv      | in
//   rsp     | rsp_valid, rsp_stall, rsp_monitor_state, | out
//           | rsp_display_inhibit, rsp_armed           |
//   csr     | csr_write, csr_index, csr_wdata          | in
//
// one transaction at a time: accept, store, sum, multiply, decide, load out. the sum
// takes one entry a cycle over the fill stored samples (at most HISTORY_DEPTH) from
// the history memory read port; once in shutdown, accept goes straight to load out.
// reset clears counters, armed latch, level and the result register; history
// memory is not cleared. a waiting result does not block the next accept, but
// the next result is held back until the previous one is taken.
module battery_protection_monitor
   import bpm_pkg::*;
#(
   parameter int HISTORY_DEPTH = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [SAMPLE_W-1:0]  req_sample_mv,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_monitor_state,
   output logic                 rsp_display_inhibit,
   output logic                 rsp_armed,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SAMPLE_W-1:0]  csr_wdata
);

   cmd_type    cmd;
   status_type status;

   bpm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   bpm_datapath #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_sample_mv       (req_sample_mv),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_monitor_state   (rsp_monitor_state),
      .rsp_display_inhibit (rsp_display_inhibit),
      .rsp_armed           (rsp_armed)
   );

endmodule

// ===== sv/bpm_checker.sv =====
// port-level checks for the battery protection monitor and their binding
module bpm_checker
   import bpm_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [1:0]          rsp_monitor_state,
   input logic                rsp_display_inhibit,
   input logic                rsp_armed
);

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_monitor_state)
         && $stable(rsp_display_inhibit) && $stable(rsp_armed))
      else $error("stalled result changed");

   a_inhibit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_display_inhibit == (rsp_monitor_state != LVL_OK))
      else $error("display inhibit does not match state");

   // the level only leaves ok once armed
   a_armed_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_monitor_state != LVL_OK |-> rsp_armed)
      else $error("level moved while not armed");

   // one transaction in work at a time
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("accepted a transaction while busy");

endmodule

bind battery_protection_monitor bpm_checker u_bpm_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_monitor_state   (rsp_monitor_state),
   .rsp_display_inhibit (rsp_display_inhibit),
   .rsp_armed           (rsp_armed)
);

// ===== dv/tb_battery_protection_monitor.sv =====
// self-checking testbench for the battery protection monitor
`timescale 1ns / 1ps

module tb_battery_protection_monitor;
   import bpm_pkg::*;

   localparam int HIST_DEPTH = 8;
   localparam int ITEMS_PER_PHASE = 90;
   localparam int PHASES = 8;
   localparam int TAIL_CYCLES = HIST_DEPTH + 12;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int HOLD_AT_FIRST = 150;
   localparam int HOLD_AT_SECOND = 500;

   // indexes past the register file, writes there must be dropped
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_LO = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_HI = 3'd7;

   typedef struct packed {
      level_type state;
      logic      inhibit;
      logic      armed;
   } verdict_t;

   typedef struct packed {
      logic [SAMPLE_W-1:0] critical;
      logic [SAMPLE_W-1:0] low;
      logic [SAMPLE_W-1:0] recover;
      logic [SAMPLE_W-1:0] high;
      logic [NEEDED_W-1:0] needed;
   } thresholds_t;

   typedef struct {
      logic                 is_csr;
      logic [CSR_IDX_W-1:0] idx;
      logic [SAMPLE_W-1:0]  value;
      logic                 typed;
      verdict_t             exp;
   } step_row_t;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [SAMPLE_W-1:0]  req_sample_mv;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [1:0]           rsp_monitor_state;
   logic                 rsp_display_inhibit;
   logic                 rsp_armed;
   logic                 csr_write;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [SAMPLE_W-1:0]  csr_wdata;

   // predictor copy of the configuration and of the monitor state
   logic [SAMPLE_W-1:0] cfg_critical = CRITICAL_MV_RST;
   logic [SAMPLE_W-1:0] cfg_low = LOW_MV_RST;
   logic [SAMPLE_W-1:0] cfg_recover = RECOVER_MV_RST;
   logic [SAMPLE_W-1:0] cfg_high = HIGH_MV_RST;
   logic [NEEDED_W-1:0] cfg_needed = HIGH_NEEDED_RST;

   logic [SAMPLE_W-1:0] trk_hist [HIST_DEPTH];
   int                  trk_wr_ptr = 0;
   int                  trk_fill = 0;
   logic [NEEDED_W-1:0] trk_high_cnt = '0;
   logic                trk_armed = 1'b0;
   level_type           trk_level = LVL_OK;

   verdict_t  verdicts_due[$];
   step_row_t plan[$];

   int  failures = 0;
   int  hold_cycles = 0;
   int  quiet_cycles = 0;
   bit  send_calm = 1'b0;
   bit  rsp_calm = 1'b0;

   battery_protection_monitor #(
      .HISTORY_DEPTH(HIST_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_sample_mv(req_sample_mv),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_monitor_state(rsp_monitor_state),
      .rsp_display_inhibit(rsp_display_inhibit),
      .rsp_armed(rsp_armed),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // advance the discharge tracker by one sample and return the reading it gives
   function automatic verdict_t track_discharge(input logic [SAMPLE_W-1:0] mv);
      verdict_t    v;
      int unsigned sum;
      int unsigned mean;
      int          i;
      if (trk_level != LVL_SHUTDOWN) begin
         trk_hist[trk_wr_ptr] = mv;
         trk_wr_ptr = (trk_wr_ptr + 1) % HIST_DEPTH;
         if (trk_fill < HIST_DEPTH) trk_fill++;
         if (mv >= cfg_high) begin
            if (trk_high_cnt != HIGH_COUNT_MAX) trk_high_cnt++;
            if (trk_high_cnt >= cfg_needed) trk_armed = 1'b1;
         end
         // only written entries take part, fill is at least one here
         sum = 0;
         for (i = 0; i < trk_fill; i++) sum += trk_hist[i];
         mean = sum / trk_fill;
         if (trk_armed) begin
            case (trk_level)
               LVL_OK: begin
                  if (mv <= cfg_critical) trk_level = LVL_CRITICAL;
                  else if (mv <= cfg_low && mean <= cfg_low + LOW_MARGIN_MV)
                     trk_level = LVL_LOW;
               end
               LVL_LOW: begin
                  if (mv <= cfg_critical) trk_level = LVL_CRITICAL;
                  else if (mv >= cfg_recover) trk_level = LVL_OK;
               end
               LVL_CRITICAL: trk_level = LVL_SHUTDOWN;
               default: ;
            endcase
         end
      end
      v.state = trk_level;
      v.inhibit = (trk_level != LVL_OK);
      v.armed = trk_armed;
      return v;
   endfunction

   task automatic add_row(input logic is_csr, input logic [CSR_IDX_W-1:0] idx,
                          input logic [SAMPLE_W-1:0] value, input logic typed,
                          input level_type lvl, input logic armed);
      step_row_t row;
      row.is_csr = is_csr;
      row.idx = idx;
      row.value = value;
      row.typed = typed;
      row.exp.state = lvl;
      row.exp.inhibit = (lvl != LVL_OK);
      row.exp.armed = armed;
      plan.push_back(row);
   endtask

   // entered and left at a falling edge
   task automatic offer_sample(input logic [SAMPLE_W-1:0] mv, input logic typed,
                               input verdict_t typed_exp);
      int       gap;
      verdict_t model_exp;
      gap = send_calm ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_sample_mv <= mv;
      do @(posedge clock); while (req_stall !== 1'b0);
      model_exp = track_discharge(mv);
      verdicts_due.push_back(typed ? typed_exp : model_exp);
      @(negedge clock);
   endtask

   // stop offering and wait for every outstanding reading
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (verdicts_due.size() != 0);
   endtask

   task automatic csr_put(input logic [CSR_IDX_W-1:0] idx, input logic [SAMPLE_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_CRITICAL_MV: cfg_critical = data;
         CSR_LOW_MV:      cfg_low = data;
         CSR_RECOVER_MV:  cfg_recover = data;
         CSR_HIGH_MV:     cfg_high = data;
         CSR_HIGH_NEEDED: cfg_needed = data[NEEDED_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_write <= 1'b0;
      @(negedge clock);
   endtask

   task automatic apply_thresholds(input thresholds_t t);
      logic [SAMPLE_W-NEEDED_W-1:0] junk;
      junk = (SAMPLE_W-NEEDED_W)'($urandom_range(0, 255));
      drain_results();
      csr_put(CSR_CRITICAL_MV, t.critical);
      csr_put(CSR_LOW_MV, t.low);
      csr_put(CSR_RECOVER_MV, t.recover);
      csr_put(CSR_HIGH_MV, t.high);
      // upper data bits are junk, only the low nibble lands
      csr_put(CSR_HIGH_NEEDED, {junk, t.needed});
   endtask

   // result side: random stall per transaction plus two long hold-offs
   initial begin
      int taken;
      taken = 0;
      rsp_stall = 1'b1;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            taken++;
            hold_cycles = rsp_calm ? 0 : $urandom_range(0, 9);
            if (taken == HOLD_AT_FIRST || taken == HOLD_AT_SECOND)
               hold_cycles = HOLD_OFF_CYCLES;
         end
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_cycles--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      verdict_t exp;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (verdicts_due.size() == 0) begin
            failures++;
            $display("%0t: unexpected reading state %0d inhibit %0b armed %0b", $time,
                     rsp_monitor_state, rsp_display_inhibit, rsp_armed);
         end else begin
            exp = verdicts_due.pop_front();
            if (rsp_monitor_state !== exp.state) begin
               failures++;
               $display("%0t: monitor_state expected %0d actual %0d", $time,
                        exp.state, rsp_monitor_state);
            end
            if (rsp_display_inhibit !== exp.inhibit) begin
               failures++;
               $display("%0t: display_inhibit expected %0b actual %0b", $time,
                        exp.inhibit, rsp_display_inhibit);
            end
            if (rsp_armed !== exp.armed) begin
               failures++;
               $display("%0t: armed expected %0b actual %0b", $time,
                        exp.armed, rsp_armed);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      int          p;
      int          n;
      int          r;
      int          v;
      int          burst_left;
      int          burst_kind;
      thresholds_t t;

      reset = 1'b1;
      req_valid = 1'b0;
      req_sample_mv = '0;
      csr_write = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      for (r = 0; r < HIST_DEPTH; r++) trk_hist[r] = '0;

      // unarmed samples never move the level, arming comes from high samples
      add_row(1'b0, '0, 12'd0,    1'b1, LVL_OK, 1'b0);
      add_row(1'b0, '0, 12'd4095, 1'b1, LVL_OK, 1'b0);
      add_row(1'b0, '0, 12'd3500, 1'b1, LVL_OK, 1'b0);
      add_row(1'b0, '0, 12'd3499, 1'b1, LVL_OK, 1'b0);
      add_row(1'b0, '0, 12'd4095, 1'b1, LVL_OK, 1'b0);
      add_row(1'b1, CSR_UNUSED_LO, 12'd0,    1'b0, LVL_OK, 1'b0);
      add_row(1'b1, CSR_UNUSED_HI, 12'hfff,  1'b0, LVL_OK, 1'b0);
      // zero needed count arms on the next high sample
      add_row(1'b1, CSR_HIGH_NEEDED, 12'd0,  1'b0, LVL_OK, 1'b0);
      add_row(1'b0, '0, 12'd3499, 1'b1, LVL_OK, 1'b0);
      add_row(1'b0, '0, 12'd2048, 1'b1, LVL_OK, 1'b0);
      add_row(1'b0, '0, 12'd4095, 1'b1, LVL_OK, 1'b1);
      // sag at the low level, the history average holds it off for a while
      for (r = 0; r < 5; r++) add_row(1'b0, '0, 12'd3300, 1'b0, LVL_OK, 1'b0);
      add_row(1'b0, '0, 12'd3399, 1'b0, LVL_OK, 1'b0);
      add_row(1'b0, '0, 12'd3400, 1'b1, LVL_OK, 1'b1);
      add_row(1'b0, '0, 12'd3301, 1'b0, LVL_OK, 1'b0);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_calm = ($urandom_range(0, 3) == 0);
      rsp_calm = ($urandom_range(0, 3) == 0);
      for (r = 0; r < plan.size(); r++) begin
         if (plan[r].is_csr) begin
            drain_results();
            csr_put(plan[r].idx, plan[r].value);
         end else begin
            offer_sample(plan[r].value, plan[r].typed, plan[r].exp);
         end
      end

      // random phases keep every sample above the critical level
      for (p = 0; p < PHASES; p++) begin
         case (p)
            0: t = '{12'd0, 12'd4095, 12'd4095, 12'd0, 4'd15};
            3: t = '{12'd0, 12'd0, 12'd0, 12'd4095, 4'd1};
            6: t = '{CRITICAL_MV_RST, LOW_MV_RST, RECOVER_MV_RST, HIGH_MV_RST,
                     HIGH_NEEDED_RST};
            default: begin
               t.critical = SAMPLE_W'($urandom_range(0, 2000));
               t.low = SAMPLE_W'($urandom_range(0, 4095));
               t.recover = SAMPLE_W'($urandom_range(0, 4095));
               t.high = SAMPLE_W'($urandom_range(0, 4095));
               t.needed = NEEDED_W'($urandom_range(0, 15));
            end
         endcase
         apply_thresholds(t);
         send_calm = ($urandom_range(0, 3) == 0);
         rsp_calm = ($urandom_range(0, 3) == 0);
         burst_left = 0;
         burst_kind = 0;
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            if ($urandom_range(0, 59) == 0) drain_results();
            // runs of sag, recovery, high or noise so the average can follow
            if (burst_left == 0) begin
               burst_kind = $urandom_range(0, 3);
               burst_left = $urandom_range(4, 12);
            end
            burst_left--;
            case (burst_kind)
               0: v = int'(t.low) - int'($urandom_range(0, 150));
               1: v = int'(t.recover) + int'($urandom_range(0, 80)) - 40;
               2: v = int'(t.high) + int'($urandom_range(0, 300));
               default: v = $urandom_range(0, 4095);
            endcase
            if (v > 4095) v = 4095;
            if (v <= int'(t.critical))
               v = int'(t.critical) + 1 + int'($urandom_range(0, 4094 - t.critical));
            offer_sample(v[SAMPLE_W-1:0], 1'b0, '0);
         end
      end

      // closing phase: critical, possibly by way of low, then shutdown for good
      t.critical = 12'd1000;
      t.low = 12'd4095;
      t.recover = 12'd4095;
      t.high = SAMPLE_W'($urandom_range(0, 4095));
      t.needed = NEEDED_W'($urandom_range(0, 15));
      apply_thresholds(t);
      send_calm = ($urandom_range(0, 1) == 0);
      if ($urandom_range(0, 1)) offer_sample(12'd2000, 1'b0, '0);
      offer_sample(SAMPLE_W'($urandom_range(0, 1000)), 1'b0, '0);
      for (n = 0; n < 12; n++) offer_sample(SAMPLE_W'($urandom_range(0, 4095)), 1'b0, '0);

      drain_results();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
